// ===== rtl/core/sha0_pkg.sv =====
// ----------------------------------------------------------------------------
// sha0_pkg
// Types, constants and round functions shared by the SHA-0 engine files.
// ----------------------------------------------------------------------------
package sha0_pkg;

  localparam int unsigned COUNT_W   = 61;
  localparam int unsigned ROUNDS    = 80;
  localparam int unsigned RND_W     = 7;
  localparam int unsigned CHAIN_N   = 5;
  localparam int unsigned IDX_W     = 3;

  localparam logic [7:0]  MARK_BYTE   = 8'h80;
  localparam logic [5:0]  POS_LEN     = 6'd56;
  localparam logic [5:0]  POS_LAST    = 6'd63;
  localparam logic [IDX_W-1:0] LAST_IDX = 3'd4;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef logic [CHAIN_N-1:0][31:0] chain_t;

  // Element 0 holds h0.
  localparam chain_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                               32'hEFCDAB89, 32'h67452301};

  typedef struct packed {
    logic       is_end;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [31:0]      digest_word;
    logic [IDX_W-1:0] word_index;
    logic             last_word;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PAD_MARK,
    PAD_ZERO,
    PAD_LEN,
    PAD_DONE
  } pad_t;

  function automatic logic [31:0] round_k(input logic [RND_W-1:0] t);
    logic [31:0] k;
    if (t inside {[7'd0:7'd19]}) begin
      k = K0;
    end else if (t inside {[7'd20:7'd39]}) begin
      k = K1;
    end else if (t inside {[7'd40:7'd59]}) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [RND_W-1:0] t,
                                          input logic [31:0] b,
                                          input logic [31:0] c,
                                          input logic [31:0] d);
    logic [31:0] f;
    if (t inside {[7'd0:7'd19]}) begin
      f = (b & c) ^ (~b & d);
    end else if (t inside {[7'd40:7'd59]}) begin
      f = (b & c) ^ (b & d) ^ (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

// ===== rtl/core/sha0_hash_engine.sv =====
// ----------------------------------------------------------------------------
// sha0_hash_engine
// SHA-0 digest of a byte stream, five digest words per end-of-message word.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  in       in         push / full        in_kind, in_data_byte
//  out      out        empty / pop        out_digest_word, out_word_index,
//                                          out_last_word
//
// Each data byte is absorbed into the message window; each 64th byte starts a
// compression (80 rounds of the single round unit plus the chaining add),
// during which no new byte is taken.
// An end word is accepted, padded, and finished with one or two compressions
// and the emit of five digest words. Reset is synchronous and loads the initial
// chaining values; the message window needs no clearing. full rises when the
// command queue holds IN_DEPTH words, and the core stalls its emit while the
// result queue is full.
module sha0_hash_engine #(
  parameter int unsigned IN_DEPTH  = 4,
  parameter int unsigned OUT_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha0_pkg::cmd_t cmd;
  logic           cmd_valid, cmd_ready;
  sha0_pkg::res_t res, res_q;
  logic           res_push, res_full;

  sha0_front #(
    .DEPTH(IN_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .kind     (in_kind),
    .data_byte(in_data_byte),
    .full     (full),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_ready(cmd_ready)
  );

  sha0_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_ready(cmd_ready),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full)
  );

  sha0_fifo #(
    .WIDTH($bits(sha0_pkg::res_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .din  (res),
    .full (res_full),
    .pop  (pop),
    .dout (res_q),
    .empty(empty)
  );

  assign out_digest_word = res_q.digest_word;
  assign out_word_index  = res_q.word_index;
  assign out_last_word   = res_q.last_word;

endmodule

// ===== rtl/core/sha0_fifo.sv =====
// ----------------------------------------------------------------------------
// sha0_fifo
// Small first-word-fall-through queue built from registers.
// ----------------------------------------------------------------------------
module sha0_fifo #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== rtl/core/sha0_front.sv =====
// ----------------------------------------------------------------------------
// sha0_front
// Input side: classifies each incoming word as data or end of message and
// queues the resulting command for the hash core.
// ----------------------------------------------------------------------------
module sha0_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              kind,
  input  logic [7:0]        data_byte,
  output logic              full,
  output logic              cmd_valid,
  output sha0_pkg::cmd_t    cmd,
  input  logic              cmd_ready
);

  sha0_pkg::cmd_t cmd_in;
  logic           q_empty;

  // The byte of an end word carries no meaning, so it is cleared here.
  always_comb begin
    cmd_in.is_end = kind;
    cmd_in.data   = kind ? 8'h00 : data_byte;
  end

  sha0_fifo #(
    .WIDTH($bits(sha0_pkg::cmd_t)),
    .DEPTH(DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .din  (cmd_in),
    .full (full),
    .pop  (cmd_ready),
    .dout (cmd),
    .empty(q_empty)
  );

  assign cmd_valid = !q_empty;

endmodule

// ===== rtl/core/sha0_back.sv =====
// ----------------------------------------------------------------------------
// sha0_back
// Hash core: packs bytes into the message window, runs one SHA-0 round per
// cycle, applies padding on an end command and emits the digest words.
// ----------------------------------------------------------------------------
module sha0_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  sha0_pkg::cmd_t cmd,
  output logic           cmd_ready,
  output logic           res_push,
  output sha0_pkg::res_t res,
  input  logic           res_full
);

  sha0_pkg::state_t                   state_r, state_nxt;
  sha0_pkg::pad_t                     pad_r, pad_nxt;
  logic                               pad_act_r, pad_act_nxt;
  logic [2:0]                         len_cnt_r, len_cnt_nxt;
  logic [63:0]                        len_r, len_nxt;
  logic [sha0_pkg::COUNT_W-1:0]       count_r, count_nxt;
  logic [23:0]                        acc_r, acc_nxt;
  logic [15:0][31:0]                  w_r, w_nxt;
  sha0_pkg::chain_t                   chain_r, chain_nxt;
  logic [31:0]                        a_r, b_r, c_r, d_r, e_r;
  logic [31:0]                        a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [sha0_pkg::RND_W-1:0]         rnd_r, rnd_nxt;
  logic [sha0_pkg::IDX_W-1:0]         emit_r, emit_nxt;

  logic                               absorb_en;
  logic [7:0]                         absorb_byte;
  logic [5:0]                         pos;
  logic [31:0]                        wt;

  assign pos = count_r[5:0];

  always_comb begin
    state_nxt   = state_r;
    pad_nxt     = pad_r;
    pad_act_nxt = pad_act_r;
    len_cnt_nxt = len_cnt_r;
    len_nxt     = len_r;
    count_nxt   = count_r;
    acc_nxt     = acc_r;
    w_nxt       = w_r;
    chain_nxt   = chain_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    c_nxt       = c_r;
    d_nxt       = d_r;
    e_nxt       = e_r;
    rnd_nxt     = rnd_r;
    emit_nxt    = emit_r;
    absorb_en   = 1'b0;
    absorb_byte = 8'h00;
    cmd_ready   = 1'b0;
    res_push    = 1'b0;
    res.digest_word = chain_r[emit_r];
    res.word_index  = emit_r;
    res.last_word   = (emit_r == sha0_pkg::LAST_IDX);
    wt = (rnd_r < 7'd16) ? w_r[0] : (w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0]);

    case (state_r)
      sha0_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (cmd.is_end) begin
            len_nxt     = {count_r, 3'b000};
            pad_act_nxt = 1'b1;
            pad_nxt     = sha0_pkg::PAD_MARK;
            len_cnt_nxt = '0;
            state_nxt   = sha0_pkg::ST_PAD;
          end else begin
            absorb_en   = 1'b1;
            absorb_byte = cmd.data;
          end
        end
      end

      sha0_pkg::ST_PAD: begin
        case (pad_r)
          sha0_pkg::PAD_MARK: begin
            absorb_en   = 1'b1;
            absorb_byte = sha0_pkg::MARK_BYTE;
            pad_nxt     = sha0_pkg::PAD_ZERO;
          end
          sha0_pkg::PAD_ZERO: begin
            if (pos == sha0_pkg::POS_LEN) begin
              pad_nxt = sha0_pkg::PAD_LEN;
            end else begin
              absorb_en = 1'b1;
            end
          end
          sha0_pkg::PAD_LEN: begin
            absorb_en   = 1'b1;
            absorb_byte = len_r[63:56];
            len_nxt     = {len_r[55:0], 8'h00};
            len_cnt_nxt = len_cnt_r + 1'b1;
            if (len_cnt_r == 3'd7) begin
              pad_nxt = sha0_pkg::PAD_DONE;
            end
          end
          default: begin
            state_nxt = sha0_pkg::ST_EMIT;
          end
        endcase
      end

      sha0_pkg::ST_ROUND: begin
        w_nxt = {wt, w_r[15:1]};
        a_nxt = {a_r[26:0], a_r[31:27]} + sha0_pkg::round_f(rnd_r, b_r, c_r, d_r)
                + e_r + sha0_pkg::round_k(rnd_r) + wt;
        b_nxt = a_r;
        c_nxt = {b_r[1:0], b_r[31:2]};
        d_nxt = c_r;
        e_nxt = d_r;
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == sha0_pkg::RND_W'(sha0_pkg::ROUNDS - 1)) begin
          state_nxt = sha0_pkg::ST_FOLD;
        end
      end

      sha0_pkg::ST_FOLD: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        chain_nxt[4] = chain_r[4] + e_r;
        if (!pad_act_r) begin
          state_nxt = sha0_pkg::ST_IDLE;
        end else if (pad_r == sha0_pkg::PAD_DONE) begin
          state_nxt = sha0_pkg::ST_EMIT;
        end else begin
          state_nxt = sha0_pkg::ST_PAD;
        end
      end

      sha0_pkg::ST_EMIT: begin
        if (!res_full) begin
          res_push = 1'b1;
          emit_nxt = emit_r + 1'b1;
          if (emit_r == sha0_pkg::LAST_IDX) begin
            chain_nxt   = sha0_pkg::H_INIT;
            count_nxt   = '0;
            pad_act_nxt = 1'b0;
            emit_nxt    = '0;
            state_nxt   = sha0_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = sha0_pkg::ST_IDLE;
      end
    endcase

    // Bytes gather in a three-byte accumulator; a completed word shifts into
    // the top of the message window, so word 0 ends up at the bottom.
    if (absorb_en) begin
      acc_nxt   = {acc_r[15:0], absorb_byte};
      count_nxt = count_r + 1'b1;
      if (pos[1:0] == 2'b11) begin
        w_nxt = {{acc_r, absorb_byte}, w_r[15:1]};
      end
      if (pos == sha0_pkg::POS_LAST) begin
        state_nxt = sha0_pkg::ST_ROUND;
        rnd_nxt   = '0;
        a_nxt     = chain_r[0];
        b_nxt     = chain_r[1];
        c_nxt     = chain_r[2];
        d_nxt     = chain_r[3];
        e_nxt     = chain_r[4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sha0_pkg::ST_IDLE;
      pad_r     <= sha0_pkg::PAD_MARK;
      pad_act_r <= 1'b0;
      len_cnt_r <= '0;
      count_r   <= '0;
      chain_r   <= sha0_pkg::H_INIT;
      rnd_r     <= '0;
      emit_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      pad_r     <= pad_nxt;
      pad_act_r <= pad_act_nxt;
      len_cnt_r <= len_cnt_nxt;
      count_r   <= count_nxt;
      chain_r   <= chain_nxt;
      rnd_r     <= rnd_nxt;
      emit_r    <= emit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    acc_r <= acc_nxt;
    w_r   <= w_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
  end

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha0_pkg::ST_ROUND) |-> (rnd_r < 7'd80))
    else $error("round counter beyond the last round");

  a_block_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (absorb_en && (pos == sha0_pkg::POS_LAST)) |=> (state_r == sha0_pkg::ST_ROUND))
    else $error("full block did not start compression");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("digest word pushed into a full queue");

  a_digest_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.last_word) |=> ((count_r == '0) && (chain_r == sha0_pkg::H_INIT)))
    else $error("engine not restarted after the last digest word");

endmodule
